// ----- design/fpp_crc_pkg.sv -----
// Shared constants and types for the framed packet parser with CRC-16 check.
package fpp_crc_pkg;

   // parse phase codes
   localparam logic [3:0] PH_HEAD1 = 4'd0;
   localparam logic [3:0] PH_HEAD2 = 4'd1;
   localparam logic [3:0] PH_LENH  = 4'd2;
   localparam logic [3:0] PH_LENL  = 4'd3;
   localparam logic [3:0] PH_CMD   = 4'd4;
   localparam logic [3:0] PH_DATA  = 4'd5;
   localparam logic [3:0] PH_CRCH  = 4'd6;
   localparam logic [3:0] PH_CRCL  = 4'd7;
   localparam logic [3:0] PH_TAIL1 = 4'd8;
   localparam logic [3:0] PH_TAIL2 = 4'd9;

   // configuration register indexes
   localparam logic [1:0] CSR_HEADER  = 2'd0;
   localparam logic [1:0] CSR_TRAILER = 2'd1;
   localparam logic [1:0] CSR_CRC_EN  = 2'd2;

   // register reset values
   localparam logic [15:0] HEADER_RESET  = 16'hAA55;
   localparam logic [15:0] TRAILER_RESET = 16'h0D0A;

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [6:0]  count_type;

endpackage

// ----- design/framed_packet_parser_crc16_top.sv -----
// Framed byte-stream parser with bit-serial CRC-16 check and payload store.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid, req_ready, req_rx_byte       | in
//  result  | rsp_valid, rsp_ready, rsp_command, ...  | out
//  config  | csr_we, csr_index, csr_wdata            | in
//
// Each accepted byte holds off the next request while it is shifted MSB first
// through the one-bit CRC update. After a good trailer the results are read
// from the payload memory one at a time, each read registered and then loaded
// into the output register when that is free; no byte is taken until the run
// is all loaded. Reset is synchronous and needs no clearing pass.
// A result waiting in the output register does not stop the next request.
module framed_packet_parser_crc16_top #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fpp_crc_pkg::byte_type  req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fpp_crc_pkg::byte_type  rsp_command,
   output fpp_crc_pkg::count_type rsp_payload_length,
   output logic                   rsp_has_data,
   output fpp_crc_pkg::byte_type  rsp_data_byte,
   output logic [5:0]             rsp_byte_index,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  fpp_crc_pkg::word_type  csr_wdata
);
   import fpp_crc_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // configuration registers
   word_type  header_ff, trailer_ff;
   logic      crc_en_ff;

   // parser state
   logic [3:0] phase_ff, phase_in;
   logic       len_hi_zero_ff, len_hi_zero_in;
   count_type  len_ff, len_in;
   byte_type   cmd_ff, cmd_in;
   byte_type   rcrc_hi_ff, rcrc_hi_in;
   count_type  count_ff, count_in;
   logic       crc_init;
   logic       feed;
   logic       store_we;
   logic       emit_start;

   // bit-serial CRC engine
   word_type   crc_ff;
   byte_type   shift_ff;
   logic [2:0] bit_ff;
   logic       busy_ff;
   logic       feed_ff;
   logic       fb;

   // emit sequencer
   logic       emit_active_ff;
   logic       emit_pend_ff;
   count_type  emit_idx_ff;
   count_type  emit_cnt_ff;
   byte_type   mem_q_ff;
   logic       out_free;
   logic       emit_last;

   byte_type   store_mem [MAX_PAYLOAD];

   logic       req_fire;
   byte_type   b;

   assign req_ready = !busy_ff && !emit_active_ff;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_rx_byte;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         trailer_ff <= TRAILER_RESET;
         crc_en_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER:  header_ff  <= csr_wdata;
            CSR_TRAILER: trailer_ff <= csr_wdata;
            CSR_CRC_EN:  crc_en_ff  <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   // decide the next phase from the arriving byte
   always_comb begin
      phase_in       = phase_ff;
      len_hi_zero_in = len_hi_zero_ff;
      len_in         = len_ff;
      cmd_in         = cmd_ff;
      rcrc_hi_in     = rcrc_hi_ff;
      count_in       = count_ff;
      crc_init       = 1'b0;
      feed           = 1'b0;
      store_we       = 1'b0;
      emit_start     = 1'b0;
      case (phase_ff)
         PH_HEAD1: begin
            if (b == header_ff[15:8]) phase_in = PH_HEAD2;
         end
         PH_HEAD2: begin
            if (b == header_ff[7:0]) begin
               crc_init = 1'b1;
               phase_in = PH_LENH;
            end else begin
               phase_in = PH_HEAD1;
            end
         end
         PH_LENH: begin
            len_hi_zero_in = (b == 8'd0);
            feed           = 1'b1;
            phase_in       = PH_LENL;
         end
         PH_LENL: begin
            len_in = b[6:0];
            feed   = 1'b1;
            if (!len_hi_zero_ff || b == 8'd0 || b > 8'(MAX_PAYLOAD + 1))
               phase_in = PH_HEAD1;
            else
               phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = b;
            feed     = 1'b1;
            count_in = '0;
            if (len_ff == 7'd1) phase_in = crc_en_ff ? PH_CRCH : PH_TAIL1;
            else                phase_in = PH_DATA;
         end
         PH_DATA: begin
            store_we = (count_ff < 7'(MAX_PAYLOAD));
            feed     = 1'b1;
            count_in = count_ff + 7'd1;
            if (count_in >= len_ff - 7'd1)
               phase_in = crc_en_ff ? PH_CRCH : PH_TAIL1;
         end
         PH_CRCH: begin
            rcrc_hi_in = b;
            phase_in   = PH_CRCL;
         end
         PH_CRCL: begin
            if (crc_en_ff && {rcrc_hi_ff, b} != crc_ff) phase_in = PH_HEAD1;
            else                                        phase_in = PH_TAIL1;
         end
         PH_TAIL1: begin
            phase_in = (b == trailer_ff[15:8]) ? PH_TAIL2 : PH_HEAD1;
         end
         PH_TAIL2: begin
            emit_start = (b == trailer_ff[7:0]);
            phase_in   = PH_HEAD1;
         end
         default: phase_in = PH_HEAD1;
      endcase
   end

   // advance parser state on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEAD1;
         len_hi_zero_ff <= 1'b1;
         len_ff         <= '0;
         cmd_ff         <= '0;
         rcrc_hi_ff     <= '0;
         count_ff       <= '0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         len_hi_zero_ff <= len_hi_zero_in;
         len_ff         <= len_in;
         cmd_ff         <= cmd_in;
         rcrc_hi_ff     <= rcrc_hi_in;
         count_ff       <= count_in;
      end
   end

   // shift each byte MSB first through the one-bit CRC update
   assign fb = crc_ff[15] ^ shift_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         busy_ff <= 1'b0;
         feed_ff <= 1'b0;
         bit_ff  <= '0;
      end else if (req_fire) begin
         if (crc_init) crc_ff <= CRC_INIT;
         busy_ff <= 1'b1;
         feed_ff <= feed;
         bit_ff  <= '0;
      end else if (busy_ff) begin
         if (feed_ff) crc_ff <= {crc_ff[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         bit_ff <= bit_ff + 3'd1;
         if (bit_ff == 3'd7) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) shift_ff <= b;
      else          shift_ff <= {shift_ff[6:0], 1'b0};
   end

   // payload memory: write on data bytes, registered read for the emit run
   always_ff @(posedge clock) begin
      if (req_fire && store_we) store_mem[count_ff[AW-1:0]] <= b;
      if (emit_active_ff && !emit_pend_ff) mem_q_ff <= store_mem[emit_idx_ff[AW-1:0]];
   end

   // emit sequencer: read one entry, then load it when the output is free
   assign out_free  = !rsp_valid || rsp_ready;
   assign emit_last = (emit_cnt_ff == 7'd0) || (emit_idx_ff + 7'd1 == emit_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_active_ff <= 1'b0;
         emit_pend_ff   <= 1'b0;
         emit_idx_ff    <= '0;
         emit_cnt_ff    <= '0;
      end else if (req_fire && emit_start) begin
         emit_active_ff <= 1'b1;
         emit_pend_ff   <= 1'b0;
         emit_idx_ff    <= '0;
         emit_cnt_ff    <= count_ff;
      end else if (emit_active_ff) begin
         if (!emit_pend_ff) begin
            emit_pend_ff <= 1'b1;
         end else if (out_free) begin
            emit_pend_ff <= 1'b0;
            emit_idx_ff  <= emit_idx_ff + 7'd1;
            if (emit_last) emit_active_ff <= 1'b0;
         end
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (emit_active_ff && emit_pend_ff && out_free) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_active_ff && emit_pend_ff && out_free) begin
         rsp_command        <= cmd_ff;
         rsp_payload_length <= emit_cnt_ff;
         rsp_has_data       <= (emit_cnt_ff != 7'd0);
         rsp_data_byte      <= (emit_cnt_ff != 7'd0) ? mem_q_ff : 8'd0;
         rsp_byte_index     <= emit_idx_ff[5:0];
         rsp_last           <= emit_last;
      end
   end

   // checks
   a_empty_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> (rsp_last && rsp_payload_length == 7'd0))
      else $error("empty-payload result malformed");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_data) |-> ({1'b0, rsp_byte_index} < rsp_payload_length))
      else $error("byte index beyond payload length");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_active_ff |-> (emit_idx_ff <= emit_cnt_ff))
      else $error("emit index ran past run length");

endmodule

// ----- bench/framed_packet_parser_crc16_top_tb.sv -----
// Self-checking testbench for the framed packet parser with CRC-16 frame check.
module framed_packet_parser_crc16_top_tb;
   import fpp_crc_pkg::*;

   localparam int MAX_PAYLOAD   = 64;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 4000;

   // the register index past the three real ones; writes to it must be ignored
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      byte_type   command;
      count_type  payload_length;
      logic       has_data;
      byte_type   data_byte;
      logic [5:0] byte_index;
      logic       last;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   byte_type   req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   byte_type   rsp_command;
   count_type  rsp_payload_length;
   logic       rsp_has_data;
   byte_type   rsp_data_byte;
   logic [5:0] rsp_byte_index;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   word_type   csr_wdata = 16'h0000;

   // run without any idling on either side while set
   logic       no_gaps = 1'b0;
   int         fail_count = 0;
   int         idle_cycles = 0;

   byte_type         byte_backlog[$];
   byte_type         frame_buf[$];
   frame_result_type results_due[$];

   // parser copy: register values and frame state
   word_type   hdr_word = HEADER_RESET;
   word_type   tail_word = TRAILER_RESET;
   logic       crc_on = 1'b1;
   logic [3:0] parse_at = PH_HEAD1;
   word_type   frame_len = 16'h0000;
   byte_type   cmd_hold = 8'h00;
   word_type   crc_acc = CRC_INIT;
   word_type   crc_rx = 16'h0000;
   count_type  payload_seen = 7'd0;
   byte_type   payload_mem [0:MAX_PAYLOAD-1];

   // new marker value picked for the mid-frame register changes
   word_type   csr_wdata_hold;

   framed_packet_parser_crc16_top #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_command(rsp_command),
      .rsp_payload_length(rsp_payload_length),
      .rsp_has_data(rsp_has_data),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // CRC-16/CCITT-FALSE, one byte MSB first
   function automatic word_type crc_byte(input word_type crc, input byte_type b);
      int k;
      crc = crc ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
         if (crc[15])
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         else
            crc = {crc[14:0], 1'b0};
      end
      return crc;
   endfunction

   // advance the parser copy by one received byte and queue any results it releases
   function automatic void parse_byte(input byte_type b);
      frame_result_type r;
      int run_len;
      int k;
      case (parse_at)
         PH_HEAD1: begin
            if (b == hdr_word[15:8])
               parse_at = PH_HEAD2;
         end
         PH_HEAD2: begin
            if (b == hdr_word[7:0]) begin
               crc_acc = CRC_INIT;
               parse_at = PH_LENH;
            end else begin
               parse_at = PH_HEAD1;
            end
         end
         PH_LENH: begin
            frame_len = {b, 8'h00};
            crc_acc = crc_byte(crc_acc, b);
            parse_at = PH_LENL;
         end
         PH_LENL: begin
            frame_len[7:0] = b;
            crc_acc = crc_byte(crc_acc, b);
            if (frame_len == 16'd0 || frame_len > MAX_PAYLOAD + 1)
               parse_at = PH_HEAD1;
            else
               parse_at = PH_CMD;
         end
         PH_CMD: begin
            cmd_hold = b;
            crc_acc = crc_byte(crc_acc, b);
            payload_seen = 7'd0;
            if (frame_len != 16'd1)
               parse_at = PH_DATA;
            else
               parse_at = crc_on ? PH_CRCH : PH_TAIL1;
         end
         PH_DATA: begin
            if (payload_seen < MAX_PAYLOAD)
               payload_mem[payload_seen[5:0]] = b;
            crc_acc = crc_byte(crc_acc, b);
            payload_seen = payload_seen + 7'd1;
            if (payload_seen >= frame_len - 16'd1)
               parse_at = crc_on ? PH_CRCH : PH_TAIL1;
         end
         PH_CRCH: begin
            crc_rx = {b, 8'h00};
            parse_at = PH_CRCL;
         end
         PH_CRCL: begin
            crc_rx[7:0] = b;
            parse_at = (crc_on && crc_acc != crc_rx) ? PH_HEAD1 : PH_TAIL1;
         end
         PH_TAIL1: begin
            parse_at = (b == tail_word[15:8]) ? PH_TAIL2 : PH_HEAD1;
         end
         PH_TAIL2: begin
            if (b == tail_word[7:0]) begin
               run_len = (payload_seen > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_seen;
               r.command = cmd_hold;
               r.payload_length = 7'(run_len);
               if (run_len == 0) begin
                  r.has_data = 1'b0;
                  r.data_byte = 8'h00;
                  r.byte_index = 6'd0;
                  r.last = 1'b1;
                  results_due = {results_due, r};
               end
               for (k = 0; k < run_len; k++) begin
                  r.has_data = 1'b1;
                  r.data_byte = payload_mem[k];
                  r.byte_index = 6'(k);
                  r.last = (k == run_len - 1);
                  results_due = {results_due, r};
               end
            end
            parse_at = PH_HEAD1;
         end
         default: begin
            parse_at = PH_HEAD1;
         end
      endcase
   endfunction

   // request side: hold a request until taken, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            parse_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (byte_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
               req_valid <= 1'b1;
               req_rx_byte <= byte_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: stall at random and check each taken result against the oldest due
   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result: cmd=%h len=%0d has=%b data=%h idx=%0d last=%b",
                        $time, rsp_command, rsp_payload_length, rsp_has_data,
                        rsp_data_byte, rsp_byte_index, rsp_last);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_command !== want.command ||
                   rsp_payload_length !== want.payload_length ||
                   rsp_has_data !== want.has_data ||
                   rsp_data_byte !== want.data_byte ||
                   rsp_byte_index !== want.byte_index ||
                   rsp_last !== want.last) begin
                  $display("%0t: mismatch: expected %h/%0d/%b/%h/%0d/%b, actual %h/%0d/%b/%h/%0d/%b",
                           $time, want.command, want.payload_length, want.has_data,
                           want.data_byte, want.byte_index, want.last,
                           rsp_command, rsp_payload_length, rsp_has_data,
                           rsp_data_byte, rsp_byte_index, rsp_last);
                  fail_count++;
               end
            end
         end
         rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 10);
      end
   end

   // drop the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_word(input word_type w);
      byte_backlog = {byte_backlog, w[15:8]};
      byte_backlog = {byte_backlog, w[7:0]};
   endtask

   task automatic queue_bytes(input int from, input int upto);
      int i;
      for (i = from; i < upto; i++)
         byte_backlog = {byte_backlog, frame_buf[i]};
   endtask

   // assemble one frame with a random payload into frame_buf
   task automatic build_frame(input word_type hdr, input word_type len, input byte_type cmd,
                              input int n_data, input logic with_crc, input word_type tail);
      word_type crc;
      byte_type b;
      int i;
      frame_buf.delete();
      frame_buf = {frame_buf, hdr[15:8]};
      frame_buf = {frame_buf, hdr[7:0]};
      frame_buf = {frame_buf, len[15:8]};
      frame_buf = {frame_buf, len[7:0]};
      frame_buf = {frame_buf, cmd};
      crc = crc_byte(crc_byte(crc_byte(CRC_INIT, len[15:8]), len[7:0]), cmd);
      for (i = 0; i < n_data; i++) begin
         b = 8'($urandom);
         frame_buf = {frame_buf, b};
         crc = crc_byte(crc, b);
      end
      if (with_crc) begin
         frame_buf = {frame_buf, crc[15:8]};
         frame_buf = {frame_buf, crc[7:0]};
      end
      frame_buf = {frame_buf, tail[15:8]};
      frame_buf = {frame_buf, tail[7:0]};
   endtask

   // wait until every request is taken, every result is in and the block has gone quiet
   task automatic settle();
      do
         @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register while the block is quiet, and mirror it in the parser copy
   task automatic write_csr(input logic [1:0] index, input word_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_HEADER:  hdr_word = value;
         CSR_TRAILER: tail_word = value;
         CSR_CRC_EN:  crc_on = value[0];
         default: ;
      endcase
   endtask

   // send frame_buf in two parts with a register write in between
   task automatic split_frame(input int cut, input logic [1:0] index, input word_type value);
      queue_bytes(0, cut);
      settle();
      write_csr(index, value);
      queue_bytes(cut, frame_buf.size());
      settle();
   endtask

   // mostly well-formed frames of random content, with stray bytes and broken frames mixed in
   task automatic random_traffic(input int budget);
      int sent;
      int kind;
      int n;
      byte_type flip;
      word_type bad_len;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, MAX_PAYLOAD) : $urandom_range(0, 6);
         flip = 8'($urandom_range(1, 255));
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) byte_backlog = {byte_backlog, 8'($urandom)};
         if (kind >= 90) begin
            // length out of range: zero or past the payload limit
            bad_len = (kind >= 95) ? 16'($urandom_range(MAX_PAYLOAD + 2, 65535)) : 16'd0;
            queue_word(hdr_word);
            queue_word(bad_len);
            sent += 4;
         end else begin
            build_frame(hdr_word, 16'(n + 1), 8'($urandom), n, crc_on, tail_word);
            if (kind >= 70 && kind < 75)
               frame_buf[1] = frame_buf[1] ^ flip;
            else if (kind >= 75 && kind < 80)
               frame_buf[frame_buf.size() - 2] = frame_buf[frame_buf.size() - 2] ^ flip;
            else if (kind >= 80 && kind < 85)
               frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ flip;
            else if (kind >= 85)
               frame_buf[frame_buf.size() - 3] = frame_buf[frame_buf.size() - 3] ^ flip;
            queue_bytes(0, frame_buf.size());
            sent += frame_buf.size();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty payload frame under the reset register values
      build_frame(HEADER_RESET, 16'd1, 8'h00, 0, 1'b1, TRAILER_RESET);
      queue_bytes(0, frame_buf.size());
      // bad second header byte equal to the first: it must not restart the frame
      byte_backlog = {byte_backlog, HEADER_RESET[15:8]};
      byte_backlog = {byte_backlog, HEADER_RESET[15:8]};
      build_frame(HEADER_RESET, 16'd1, 8'hFF, 0, 1'b1, TRAILER_RESET);
      queue_bytes(1, frame_buf.size());
      // bad first trailer byte, then a frame that lacks its first header byte
      build_frame(HEADER_RESET, 16'd2, 8'h5A, 1, 1'b1, {HEADER_RESET[15:8], 8'h00});
      queue_bytes(0, frame_buf.size() - 1);
      build_frame(HEADER_RESET, 16'd1, 8'hA5, 0, 1'b1, TRAILER_RESET);
      queue_bytes(1, frame_buf.size());
      // bad second trailer byte, same follow-up
      build_frame(HEADER_RESET, 16'd2, 8'h3C, 1, 1'b1, {TRAILER_RESET[15:8], HEADER_RESET[15:8]});
      queue_bytes(0, frame_buf.size());
      build_frame(HEADER_RESET, 16'd1, 8'hC3, 0, 1'b1, TRAILER_RESET);
      queue_bytes(1, frame_buf.size());
      // lengths just outside the legal range
      queue_word(HEADER_RESET);
      queue_word(16'd0);
      queue_word(HEADER_RESET);
      queue_word(16'(MAX_PAYLOAD + 2));
      settle();

      // all-zero header, all-ones trailer, no CRC field
      write_csr(CSR_HEADER, 16'h0000);
      write_csr(CSR_TRAILER, 16'hFFFF);
      write_csr(CSR_CRC_EN, 16'h0000);
      random_traffic(20);
      settle();

      // the opposite extremes, a spare index write, and no idling on either side
      write_csr(CSR_HEADER, 16'hFFFF);
      write_csr(CSR_TRAILER, 16'h0000);
      write_csr(CSR_CRC_EN, 16'hFFFF);
      write_csr(CSR_SPARE, 16'hFFFF);
      no_gaps <= 1'b1;
      random_traffic(20);
      settle();
      no_gaps <= 1'b0;

      // random markers
      write_csr(CSR_HEADER, 16'($urandom_range(0, 65535)));
      write_csr(CSR_TRAILER, 16'($urandom_range(0, 65535)));
      write_csr(CSR_CRC_EN, 16'($urandom_range(0, 1)));
      random_traffic(15);
      settle();

      // CRC switched off after the last payload byte: wrong CRC still consumed, not compared
      write_csr(CSR_CRC_EN, 16'h0001);
      build_frame(hdr_word, 16'd3, 8'($urandom), 2, 1'b1, tail_word);
      frame_buf[8] = frame_buf[8] ^ 8'h01;
      split_frame(7, CSR_CRC_EN, 16'h0000);
      // CRC switched on after the command byte of an empty frame without CRC
      build_frame(hdr_word, 16'd1, 8'($urandom), 0, 1'b0, tail_word);
      split_frame(5, CSR_CRC_EN, 16'h0001);
      // CRC switched off between the two CRC bytes
      build_frame(hdr_word, 16'd2, 8'($urandom), 1, 1'b1, tail_word);
      frame_buf[7] = frame_buf[7] ^ 8'h80;
      split_frame(7, CSR_CRC_EN, 16'h0000);
      // CRC switched on before the last payload byte of a frame built without one
      build_frame(hdr_word, 16'd3, 8'($urandom), 2, 1'b0, tail_word);
      split_frame(6, CSR_CRC_EN, 16'h0001);
      // trailer changed just before the trailer arrives
      csr_wdata_hold = 16'($urandom_range(0, 65535));
      build_frame(hdr_word, 16'd2, 8'($urandom), 1, 1'b1, csr_wdata_hold);
      split_frame(frame_buf.size() - 2, CSR_TRAILER, csr_wdata_hold);
      // header changed between the two header bytes
      csr_wdata_hold = 16'($urandom_range(0, 65535));
      build_frame({hdr_word[15:8], csr_wdata_hold[7:0]}, 16'd1, 8'($urandom), 0, 1'b1,
                  tail_word);
      split_frame(1, CSR_HEADER, csr_wdata_hold);
      // spare index written mid-frame changes nothing
      build_frame(hdr_word, 16'd3, 8'($urandom), 2, 1'b1, tail_word);
      split_frame(4, CSR_SPARE, 16'($urandom_range(0, 65535)));

      // back to reset values, one frame of the largest payload, then more traffic
      write_csr(CSR_HEADER, HEADER_RESET);
      write_csr(CSR_TRAILER, TRAILER_RESET);
      write_csr(CSR_CRC_EN, 16'h0001);
      build_frame(hdr_word, 16'(MAX_PAYLOAD + 1), 8'($urandom), MAX_PAYLOAD, crc_on, tail_word);
      queue_bytes(0, frame_buf.size());
      random_traffic(15);
      settle();

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
design/fpp_crc_pkg.sv
design/framed_packet_parser_crc16_top.sv
bench/framed_packet_parser_crc16_top_tb.sv
